// ===== rtl/cdtb_pkg.sv =====
// ----------------------------------------------------------------------------
// cdtb_pkg
// Shared constants and types of the channel/dim corner-turn buffer.
// ----------------------------------------------------------------------------
package cdtb_pkg;

   // configuration register file
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;
   localparam int SIZE_W      = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPATIAL_SIZE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIRECTION     = 2'd2;

   // item kinds
   localparam logic MODE_DATA  = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // transpose direction
   localparam logic DIR_FORWARD  = 1'b0;
   localparam logic DIR_BACKWARD = 1'b1;

   // memory operations issued for one accepted item
   typedef struct packed {
      logic wr_en;
      logic wr_bank;
      logic rd_en;
      logic rd_bank;
      logic rd_last;
   } mem_op_type;

endpackage

// ===== rtl/channel_dim_transpose_buffer_core.sv =====
// ----------------------------------------------------------------------------
// channel_dim_transpose_buffer_core
// Corner-turn buffer: row-order elements fill one of two ping-pong banks,
// the finished frame is read back in transposed order.
//
//   channel   ports                                   direction
//   req       req_valid req_stall req_mode req_in_value   in
//   rsp       rsp_valid rsp_stall rsp_out_value            out
//             rsp_frame_last
//   csr       csr_write_enable csr_index csr_write_data    in
//
// one item per cycle while req_stall is low; the bank read is registered, so a
// result passes the read stage, then the output register
// synchronous active-high reset clears counters, bank select and valids;
// bank contents are not cleared and no clearing pass is needed
// req_stall rises only when both the read stage and a stalled output hold items
// ----------------------------------------------------------------------------
module channel_dim_transpose_buffer_core #(
   parameter int MAX_CHANNELS = 64,
   parameter int MAX_SPATIAL  = 64,
   parameter int DATA_WIDTH   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [DATA_WIDTH-1:0]               req_in_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [DATA_WIDTH-1:0]               rsp_out_value,
   output logic                                rsp_frame_last,
   input  logic                                csr_write_enable,
   input  logic [cdtb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [cdtb_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int BANK_DEPTH = MAX_CHANNELS * MAX_SPATIAL;
   localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   logic [cdtb_pkg::SIZE_W-1:0] channel_count_ff, channel_count_in;
   logic [cdtb_pkg::SIZE_W-1:0] spatial_size_ff, spatial_size_in;
   logic                        direction_ff, direction_in;
   logic                        restart;

   cdtb_pkg::mem_op_type        op;
   logic [ADDR_W-1:0]           wr_addr;
   logic [ADDR_W-1:0]           rd_addr;
   logic [DATA_WIDTH-1:0]       bank0_rd_data;
   logic [DATA_WIDTH-1:0]       bank1_rd_data;

   logic                        accept;
   logic                        s1_move;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_bank_ff, s1_bank_in;
   logic                        s1_last_ff, s1_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]       rsp_value_ff, rsp_value_in;
   logic                        rsp_last_ff, rsp_last_in;

   // configuration registers; any listed write restarts framing
   always_comb begin
      channel_count_in = channel_count_ff;
      spatial_size_in  = spatial_size_ff;
      direction_in     = direction_ff;
      restart          = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            cdtb_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_in = csr_write_data;
               restart          = 1'b1;
            end
            cdtb_pkg::CSR_SPATIAL_SIZE: begin
               spatial_size_in = csr_write_data;
               restart         = 1'b1;
            end
            cdtb_pkg::CSR_DIRECTION: begin
               direction_in = csr_write_data[0];
               restart      = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= cdtb_pkg::SIZE_W'(1);
         spatial_size_ff  <= cdtb_pkg::SIZE_W'(1);
         direction_ff     <= cdtb_pkg::DIR_FORWARD;
      end else begin
         channel_count_ff <= channel_count_in;
         spatial_size_ff  <= spatial_size_in;
         direction_ff     <= direction_in;
      end
   end

   assign req_stall = s1_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   cdtb_ctrl #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_SPATIAL  (MAX_SPATIAL)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .accept        (accept),
      .mode          (req_mode),
      .channel_count (channel_count_ff),
      .spatial_size  (spatial_size_ff),
      .direction     (direction_ff),
      .op            (op),
      .wr_addr       (wr_addr),
      .rd_addr       (rd_addr)
   );

   cdtb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (BANK_DEPTH)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (op.wr_en && (op.wr_bank == 1'b0)),
      .wr_addr (wr_addr),
      .wr_data (req_in_value),
      .rd_en   (op.rd_en && (op.rd_bank == 1'b0)),
      .rd_addr (rd_addr),
      .rd_data (bank0_rd_data)
   );

   cdtb_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (BANK_DEPTH)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (op.wr_en && (op.wr_bank == 1'b1)),
      .wr_addr (wr_addr),
      .wr_data (req_in_value),
      .rd_en   (op.rd_en && (op.rd_bank == 1'b1)),
      .rd_addr (rd_addr),
      .rd_data (bank1_rd_data)
   );

   // read stage waits on ram data; ram output holds while no new read issues
   assign s1_move = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_bank_in   = s1_bank_ff;
      s1_last_in   = s1_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = s1_bank_ff ? bank1_rd_data : bank0_rd_data;
         rsp_last_in  = s1_last_ff;
         s1_valid_in  = 1'b0;
      end
      if (op.rd_en) begin
         s1_valid_in = 1'b1;
         s1_bank_in  = op.rd_bank;
         s1_last_in  = op.rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_bank_ff   <= s1_bank_in;
      s1_last_ff   <= s1_last_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_value  = rsp_value_ff;
   assign rsp_frame_last = rsp_last_ff;

`ifndef SYNTH
   // an item in the read stage is kept until it moves to the output
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff && $stable(s1_last_ff) && $stable(s1_bank_ff))
      else $error("read stage item lost");

   // a new result only comes from the read stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a bank read");

   // no bank read is issued while the read stage is stuck
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |-> !op.rd_en)
      else $error("bank read over a held read stage");
`endif

endmodule

// ===== rtl/cdtb_ram.sv =====
// ----------------------------------------------------------------------------
// cdtb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cdtb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/cdtb_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdtb_ctrl
// Fill and readout sequencer: write index, transposed read walk, bank swap.
// ----------------------------------------------------------------------------
module cdtb_ctrl #(
   parameter int MAX_CHANNELS = 64,
   parameter int MAX_SPATIAL  = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  restart,
   input  logic                                  accept,
   input  logic                                  mode,
   input  logic [cdtb_pkg::SIZE_W-1:0]           channel_count,
   input  logic [cdtb_pkg::SIZE_W-1:0]           spatial_size,
   input  logic                                  direction,
   output cdtb_pkg::mem_op_type                  op,
   output logic [((MAX_CHANNELS * MAX_SPATIAL > 1) ?
                  $clog2(MAX_CHANNELS * MAX_SPATIAL) : 1)-1:0] wr_addr,
   output logic [((MAX_CHANNELS * MAX_SPATIAL > 1) ?
                  $clog2(MAX_CHANNELS * MAX_SPATIAL) : 1)-1:0] rd_addr
);

   localparam int BANK_DEPTH = MAX_CHANNELS * MAX_SPATIAL;
   localparam int MAX_DIM    = (MAX_CHANNELS > MAX_SPATIAL) ? MAX_CHANNELS : MAX_SPATIAL;
   localparam int ADDR_W     = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int TOT_W      = $clog2(BANK_DEPTH + 1);
   localparam int DIM_W      = $clog2(MAX_DIM + 1);
   localparam int IDX_W      = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [DIM_W-1:0]  ch_size;
   logic [DIM_W-1:0]  sp_size;
   logic [DIM_W-1:0]  rows;
   logic [DIM_W-1:0]  cols;
   logic [TOT_W-1:0]  total;

   logic [ADDR_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]  rd_inner_ff, rd_inner_in;
   logic [IDX_W-1:0]  rd_outer_ff, rd_outer_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              fill_bank_ff, fill_bank_in;
   logic              pending_ff, pending_in;

   logic              inner_wrap;
   logic              outer_wrap;
   logic              frame_done;
   logic [DIM_W-1:0]  outer_next;

   // size 0 acts as 1, oversize saturates
   always_comb begin
      if (channel_count == '0) begin
         ch_size = DIM_W'(1);
      end else if (32'(channel_count) > MAX_CHANNELS) begin
         ch_size = DIM_W'(MAX_CHANNELS);
      end else begin
         ch_size = DIM_W'(channel_count);
      end
      if (spatial_size == '0) begin
         sp_size = DIM_W'(1);
      end else if (32'(spatial_size) > MAX_SPATIAL) begin
         sp_size = DIM_W'(MAX_SPATIAL);
      end else begin
         sp_size = DIM_W'(spatial_size);
      end
   end

   assign rows  = (direction == cdtb_pkg::DIR_BACKWARD) ? sp_size : ch_size;
   assign cols  = (direction == cdtb_pkg::DIR_BACKWARD) ? ch_size : sp_size;
   assign total = TOT_W'(TOT_W'(rows) * TOT_W'(cols));

   assign outer_next = DIM_W'(rd_outer_ff) + DIM_W'(1);
   assign inner_wrap = (DIM_W'(rd_inner_ff) + DIM_W'(1)) >= rows;
   assign outer_wrap = outer_next >= cols;
   assign frame_done = (TOT_W'(wr_idx_ff) + TOT_W'(1)) >= total;

   always_comb begin
      op.rd_en   = accept && pending_ff;
      op.rd_bank = ~fill_bank_ff;
      op.rd_last = outer_wrap && inner_wrap;
      op.wr_en   = accept && (mode == cdtb_pkg::MODE_DATA);
      op.wr_bank = fill_bank_ff;
   end

   assign wr_addr = wr_idx_ff;
   assign rd_addr = rd_addr_ff;

   always_comb begin
      wr_idx_in    = wr_idx_ff;
      rd_inner_in  = rd_inner_ff;
      rd_outer_in  = rd_outer_ff;
      rd_addr_in   = rd_addr_ff;
      fill_bank_in = fill_bank_ff;
      pending_in   = pending_ff;
      if (restart) begin
         wr_idx_in    = '0;
         rd_inner_in  = '0;
         rd_outer_in  = '0;
         rd_addr_in   = '0;
         fill_bank_in = 1'b0;
         pending_in   = 1'b0;
      end else begin
         // read walk runs down a column, then steps to the next column
         if (op.rd_en) begin
            if (op.rd_last) begin
               pending_in  = 1'b0;
               rd_inner_in = '0;
               rd_outer_in = '0;
               rd_addr_in  = '0;
            end else if (inner_wrap) begin
               rd_inner_in = '0;
               rd_outer_in = IDX_W'(outer_next);
               rd_addr_in  = ADDR_W'(outer_next);
            end else begin
               rd_inner_in = rd_inner_ff + IDX_W'(1);
               rd_addr_in  = rd_addr_ff + ADDR_W'(cols);
            end
         end
         // a completed frame takes over the readout from the start
         if (op.wr_en) begin
            if (frame_done) begin
               wr_idx_in    = '0;
               fill_bank_in = ~fill_bank_ff;
               pending_in   = 1'b1;
               rd_inner_in  = '0;
               rd_outer_in  = '0;
               rd_addr_in   = '0;
            end else begin
               wr_idx_in = wr_idx_ff + ADDR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff    <= '0;
         rd_inner_ff  <= '0;
         rd_outer_ff  <= '0;
         rd_addr_ff   <= '0;
         fill_bank_ff <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         wr_idx_ff    <= wr_idx_in;
         rd_inner_ff  <= rd_inner_in;
         rd_outer_ff  <= rd_outer_in;
         rd_addr_ff   <= rd_addr_in;
         fill_bank_ff <= fill_bank_in;
         pending_ff   <= pending_in;
      end
   end

`ifndef SYNTH
   // readout and fill never share a bank
   assert property (@(posedge clock) disable iff (reset)
      op.rd_en && op.wr_en |-> op.rd_bank != op.wr_bank)
      else $error("read and write hit the same bank");

   // write index stays inside the current frame
   assert property (@(posedge clock) disable iff (reset)
      !restart |-> TOT_W'(wr_idx_ff) < total)
      else $error("write index beyond frame size");
`endif

endmodule
